// File: rtl/core/aip_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aip_pkg: shared types and constants of the ASCII integer parser
// Character codes, base constants, default widths and the per-character
// class record that goes from the classifier to the parse core.
// ----------------------------------------------------------------------------
package aip_pkg;

  // Fixed field widths
  localparam int CHAR_W = 8;
  localparam int BASE_W = 6;

  // Default widths of the result fields
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int COUNT_WIDTH_DEF = 16;

  // Bases
  localparam logic [BASE_W-1:0] BASE_DETECT = 6'd0;
  localparam logic [BASE_W-1:0] BASE_OCT    = 6'd8;
  localparam logic [BASE_W-1:0] BASE_DEC    = 6'd10;
  localparam logic [BASE_W-1:0] BASE_HEX    = 6'd16;
  localparam logic [BASE_W-1:0] BASE_MAX    = 6'd36;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_VT    = 8'h0B;
  localparam logic [CHAR_W-1:0] CH_FF    = 8'h0C;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
  localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;
  localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7A;

  // Offset added to a letter's distance from 'a' or 'A'
  localparam logic [BASE_W-1:0] LETTER_OFS = 6'd10;

  // Class of one character
  typedef struct packed {
    logic              blank;
    logic              plus;
    logic              minus;
    logic              zero;
    logic              x_char;
    logic              is_digit;
    logic [BASE_W-1:0] dval;
  } char_class_t;

endpackage
`default_nettype wire

// File: rtl/core/aip_char_class.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aip_char_class: character classifier
// Flags whitespace, sign, zero and 'x' characters and decodes the digit
// value of 0-9, a-z and A-Z.
// ----------------------------------------------------------------------------
module aip_char_class (
  input  wire logic [aip_pkg::CHAR_W-1:0] char_code,
  output aip_pkg::char_class_t            cls
);

  logic [aip_pkg::CHAR_W-1:0] dec_ofs;
  logic [aip_pkg::CHAR_W-1:0] low_ofs;
  logic [aip_pkg::CHAR_W-1:0] up_ofs;

  assign dec_ofs = char_code - aip_pkg::CH_0;
  assign low_ofs = char_code - aip_pkg::CH_LA;
  assign up_ofs  = char_code - aip_pkg::CH_UA;

  always_comb begin
    cls.blank  = (char_code == aip_pkg::CH_SPACE) || (char_code == aip_pkg::CH_TAB) ||
                 (char_code == aip_pkg::CH_LF)    || (char_code == aip_pkg::CH_CR)  ||
                 (char_code == aip_pkg::CH_FF)    || (char_code == aip_pkg::CH_VT);
    cls.plus   = (char_code == aip_pkg::CH_PLUS);
    cls.minus  = (char_code == aip_pkg::CH_MINUS);
    cls.zero   = (char_code == aip_pkg::CH_0);
    cls.x_char = (char_code == aip_pkg::CH_LX) || (char_code == aip_pkg::CH_UX);

    // digit value; letters map to 10..35
    cls.is_digit = 1'b1;
    if (char_code >= aip_pkg::CH_0 && char_code <= aip_pkg::CH_9) begin
      cls.dval = dec_ofs[aip_pkg::BASE_W-1:0];
    end else if (char_code >= aip_pkg::CH_LA && char_code <= aip_pkg::CH_LZ) begin
      cls.dval = low_ofs[aip_pkg::BASE_W-1:0] + aip_pkg::LETTER_OFS;
    end else if (char_code >= aip_pkg::CH_UA && char_code <= aip_pkg::CH_UZ) begin
      cls.dval = up_ofs[aip_pkg::BASE_W-1:0] + aip_pkg::LETTER_OFS;
    end else begin
      cls.is_digit = 1'b0;
      cls.dval     = '0;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/aip_parse_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aip_parse_core: parse state and per-character update
// Holds phase, sign, base, accumulator and consumed count; each character
// updates them while step_en is high and may raise a result.
// ----------------------------------------------------------------------------
module aip_parse_core #(
  parameter int VALUE_WIDTH = aip_pkg::VALUE_WIDTH_DEF,
  parameter int COUNT_WIDTH = aip_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        step_en,
  input  wire logic                        start_req,
  input  wire aip_pkg::char_class_t        cls,
  input  wire logic [aip_pkg::BASE_W-1:0]  base_select,
  output logic                             emit,
  output logic [VALUE_WIDTH-1:0]           value,
  output logic [COUNT_WIDTH-1:0]           end_offset
);

  typedef enum logic [3:0] {
    PH_SPACE  = 4'b0001,
    PH_SIGN   = 4'b0010,
    PH_ZERO   = 4'b0100,
    PH_DIGITS = 4'b1000
  } phase_t;

  phase_t                       phase_r,  phase_nxt,  cur_phase;
  logic                         neg_r,    neg_nxt,    cur_neg;
  logic [aip_pkg::BASE_W-1:0]   eb_r,     eb_nxt,     cur_eb;
  logic [VALUE_WIDTH-1:0]       acc_r,    acc_nxt,    cur_acc;
  logic [COUNT_WIDTH-1:0]       cnt_r,    cnt_nxt,    cur_cnt;
  logic                         done_r,   done_nxt,   cur_done;

  logic [aip_pkg::BASE_W-1:0]   base_sat;
  logic [aip_pkg::BASE_W-1:0]   use_eb;
  logic                         sign_step;
  logic                         digit_step;
  logic                         cnt_inc;

  // bases above 36 act as 36
  assign base_sat = (base_select > aip_pkg::BASE_MAX) ? aip_pkg::BASE_MAX : base_select;

  // start flag clears the state ahead of this character
  always_comb begin
    cur_phase = start_req ? PH_SPACE : phase_r;
    cur_neg   = start_req ? 1'b0     : neg_r;
    cur_eb    = start_req ? '0       : eb_r;
    cur_acc   = start_req ? '0       : acc_r;
    cur_cnt   = start_req ? '0       : cnt_r;
    cur_done  = start_req ? 1'b0     : done_r;
  end

  // one character of parsing
  always_comb begin
    phase_nxt  = cur_phase;
    neg_nxt    = cur_neg;
    eb_nxt     = cur_eb;
    acc_nxt    = cur_acc;
    done_nxt   = cur_done;
    use_eb     = cur_eb;
    sign_step  = 1'b0;
    digit_step = 1'b0;
    cnt_inc    = 1'b0;
    emit       = 1'b0;

    if (!cur_done) begin
      unique case (cur_phase)
        PH_SPACE: begin
          if (cls.blank) begin
            cnt_inc = 1'b1;
          end else if (cls.plus || cls.minus) begin
            neg_nxt   = cls.minus;
            cnt_inc   = 1'b1;
            phase_nxt = PH_SIGN;
          end else begin
            sign_step = 1'b1;
          end
        end
        PH_SIGN: begin
          sign_step = 1'b1;
        end
        PH_ZERO: begin
          phase_nxt = PH_DIGITS;
          if (cls.x_char) begin
            cnt_inc = 1'b1;
            eb_nxt  = aip_pkg::BASE_HEX;
          end else begin
            digit_step = 1'b1;
          end
        end
        PH_DIGITS: begin
          digit_step = 1'b1;
        end
        default: begin
          phase_nxt = PH_SPACE;
        end
      endcase

      // prefix decision: leading zero in detect or hex mode
      if (sign_step) begin
        if ((base_sat == aip_pkg::BASE_DETECT || base_sat == aip_pkg::BASE_HEX) && cls.zero) begin
          cnt_inc   = 1'b1;
          eb_nxt    = (base_sat == aip_pkg::BASE_DETECT) ? aip_pkg::BASE_OCT : aip_pkg::BASE_HEX;
          phase_nxt = PH_ZERO;
        end else begin
          use_eb     = (base_sat == aip_pkg::BASE_DETECT) ? aip_pkg::BASE_DEC : base_sat;
          eb_nxt     = use_eb;
          phase_nxt  = PH_DIGITS;
          digit_step = 1'b1;
        end
      end

      // digit accumulate or stop
      if (digit_step) begin
        if (cls.is_digit && cls.dval < use_eb) begin
          acc_nxt = cur_acc * VALUE_WIDTH'(use_eb) + VALUE_WIDTH'(cls.dval);
          cnt_inc = 1'b1;
        end else begin
          emit     = 1'b1;
          done_nxt = 1'b1;
        end
      end
    end

    // saturating count
    cnt_nxt = cur_cnt;
    if (cnt_inc && cur_cnt != {COUNT_WIDTH{1'b1}}) begin
      cnt_nxt = cur_cnt + 1'b1;
    end
  end

  assign value      = cur_neg ? ('0 - cur_acc) : cur_acc;
  assign end_offset = cur_cnt;

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SPACE;
      neg_r   <= 1'b0;
      eb_r    <= '0;
      acc_r   <= '0;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      neg_r   <= neg_nxt;
      eb_r    <= eb_nxt;
      acc_r   <= acc_nxt;
      cnt_r   <= cnt_nxt;
      done_r  <= done_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/ascii_integer_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ascii_integer_parser: streaming strtol-style integer parser
// One character per beat; skips whitespace, takes a sign and a base prefix,
// accumulates digits and returns value and consumed count at the stop char.
// ----------------------------------------------------------------------------
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  in      | in_valid, in_stall, in_char_code,       | input beat
//          | in_start_req                            |
//  out     | out_valid, out_stall, out_value,        | result beat
//          | out_end_offset                          |
//  cfg     | cfg_we, cfg_wdata (base_select)         | register write
//
// One character per cycle unless the output stalls; each character beat
// passes the input register, and its result beat the result register.
// The limit is the accumulator multiply-add loop, one per cycle.
// Synchronous active-low reset clears parse state, base to 10, valids.
// A stalled result holds the output register; the input register then
// holds too and in_stall rises while it is full.
// ----------------------------------------------------------------------------
module ascii_integer_parser #(
  parameter int VALUE_WIDTH = aip_pkg::VALUE_WIDTH_DEF,
  parameter int COUNT_WIDTH = aip_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // character input
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [aip_pkg::CHAR_W-1:0]        in_char_code,
  input  wire logic                              in_start_req,
  // result output
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [VALUE_WIDTH-1:0]          out_value,
  output logic [COUNT_WIDTH-1:0]                 out_end_offset,
  // configuration
  input  wire logic                              cfg_we,
  input  wire logic [aip_pkg::BASE_W-1:0]        cfg_wdata
);

  logic                         s1_valid_r;
  logic [aip_pkg::CHAR_W-1:0]   char_r;
  logic                         start_r;
  logic [aip_pkg::BASE_W-1:0]   base_r;

  logic                         out_valid_r;
  logic [VALUE_WIDTH-1:0]       value_r;
  logic [COUNT_WIDTH-1:0]       offset_r;

  logic                         out_free;
  logic                         advance;
  aip_pkg::char_class_t         cls;
  logic                         emit;
  logic [VALUE_WIDTH-1:0]       core_value;
  logic [COUNT_WIDTH-1:0]       core_offset;

  // handshake
  assign out_free = !out_valid_r || !out_stall;
  assign advance  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;

  // base register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= aip_pkg::BASE_DEC;
    end else if (cfg_we) begin
      base_r <= cfg_wdata;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!s1_valid_r || advance) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if ((!s1_valid_r || advance) && in_valid) begin
      char_r  <= in_char_code;
      start_r <= in_start_req;
    end
  end

  aip_char_class u_class (
    .char_code (char_r),
    .cls       (cls)
  );

  aip_parse_core #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (advance),
    .start_req   (start_r),
    .cls         (cls),
    .base_select (base_r),
    .emit        (emit),
    .value       (core_value),
    .end_offset  (core_offset)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= advance && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      value_r  <= core_value;
      offset_r <= core_offset;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_value      = $signed(value_r);
  assign out_end_offset = offset_r;

endmodule
`default_nettype wire
